@@ design/smdg_pkg.sv @@
// smdg_pkg: shared types and constants of the stereo mixer with distance gain.
// Used by smdg_ctrl, smdg_datapath and stereo_mixer_distance_gain.
package smdg_pkg;

	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_VOLUME          = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LISTENER_OFFSET = 2'd3;

	localparam logic [8:0]  VOLUME_RST   = 9'd128;
	localparam logic [11:0] MIN_DIST_RST = 12'd250;
	localparam logic [11:0] LST_OFF_RST  = 12'd1125;

	localparam int SQRT_STEPS = 18;
	localparam int DIV_STEPS  = 16;
	localparam int CNT_W      = 5;

	localparam logic [16:0] GAIN_UNITY = 17'h10000;

	typedef enum logic [2:0] {
		MS_DX,
		MS_DY,
		MS_DZ,
		MS_GAIN,
		MS_SUM
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     side;
		mul_sel_t mul_sel;
		logic     d2_clr;
		logic     d2_add;
		logic     sqrt_init;
		logic     sqrt_step;
		logic     div_init;
		logic     div_step;
		logic     gain_set;
		logic     gain_unity;
		logic     acc;
		logic     lat_l;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic vv;
		logic last;
		logic spat;
		logic out_busy;
	} sts_t;

endpackage

@@ design/smdg_ctrl.sv @@
// smdg_ctrl: sequencer for one transaction at a time of the mixer.
// Depends on smdg_pkg; drives the command struct of smdg_datapath.
module smdg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  smdg_pkg::sts_t sts,
	output smdg_pkg::cmd_t cmd,
	output logic          busy
);
	import smdg_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DECIDE, S_SQ_X, S_SQ_Y, S_SQ_Z, S_SQ_ADD, S_SQRT_INIT, S_SQRT,
		S_DIV_INIT, S_DIV, S_GAIN_SET, S_GAIN_UNITY, S_GMUL, S_ACC,
		S_OUT_WAIT, S_VOL_L, S_VOL_R, S_OUT_SET
	} state_t;

	state_t           state_q;
	logic             side_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			side_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: begin
					side_q <= 1'b0;
					if (sts.vv) state_q <= sts.spat ? S_SQ_X : S_GAIN_UNITY;
					else if (sts.last) state_q <= S_OUT_WAIT;
					else state_q <= S_IDLE;
				end
				S_SQ_X:   state_q <= S_SQ_Y;
				S_SQ_Y:   state_q <= S_SQ_Z;
				S_SQ_Z:   state_q <= S_SQ_ADD;
				S_SQ_ADD: state_q <= S_SQRT_INIT;
				S_SQRT_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_GAIN_SET;
				end
				S_GAIN_SET:   state_q <= S_GMUL;
				S_GAIN_UNITY: state_q <= S_GMUL;
				S_GMUL:       state_q <= S_ACC;
				S_ACC: begin
					if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= sts.spat ? S_SQ_X : S_GAIN_UNITY;
					end else begin
						state_q <= sts.last ? S_OUT_WAIT : S_IDLE;
					end
				end
				S_OUT_WAIT: if (!sts.out_busy) state_q <= S_VOL_L;
				S_VOL_L:    state_q <= S_VOL_R;
				S_VOL_R:    state_q <= S_OUT_SET;
				S_OUT_SET:  state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MS_DX;
		cmd.side    = side_q;
		cmd.load    = (state_q == S_IDLE) && in_valid;
		unique case (state_q)
			S_SQ_X: begin
				cmd.mul_sel = MS_DX;
				cmd.d2_clr  = 1'b1;
			end
			S_SQ_Y: begin
				cmd.mul_sel = MS_DY;
				cmd.d2_add  = 1'b1;
			end
			S_SQ_Z: begin
				cmd.mul_sel = MS_DZ;
				cmd.d2_add  = 1'b1;
			end
			S_SQ_ADD:     cmd.d2_add = 1'b1;
			S_SQRT_INIT:  cmd.sqrt_init = 1'b1;
			S_SQRT:       cmd.sqrt_step = 1'b1;
			S_DIV_INIT:   cmd.div_init = 1'b1;
			S_DIV:        cmd.div_step = 1'b1;
			S_GAIN_SET:   cmd.gain_set = 1'b1;
			S_GAIN_UNITY: cmd.gain_unity = 1'b1;
			S_GMUL:       cmd.mul_sel = MS_GAIN;
			S_ACC:        cmd.acc = 1'b1;
			S_VOL_L: begin
				cmd.mul_sel = MS_SUM;
				cmd.side    = 1'b0;
			end
			S_VOL_R: begin
				cmd.mul_sel = MS_SUM;
				cmd.side    = 1'b1;
				cmd.lat_l   = 1'b1;
			end
			S_OUT_SET:    cmd.emit = 1'b1;
			default:      cmd.side = side_q;
		endcase
	end

endmodule

@@ design/smdg_datapath.sv @@
// smdg_datapath: config registers, shared multiplier, digit-serial square root,
// restoring divider, accumulators and output register. Depends on smdg_pkg.
module smdg_datapath #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smdg_pkg::cmd_t                cmd,
	output smdg_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic [smdg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smdg_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          voice_valid,
	input  logic signed [15:0]            left_sample,
	input  logic signed [15:0]            right_sample,
	input  logic                          stereo_voice,
	input  logic                          positional,
	input  logic signed [12:0]            pos_x,
	input  logic signed [12:0]            pos_y,
	input  logic signed [12:0]            pos_z,
	input  logic                          last_voice,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_left,
	output logic signed [SAMPLE_BITS-1:0] out_right,
	output logic                          clipped
);
	import smdg_pkg::*;

	localparam int VW = 26;
	localparam logic signed [VW-1:0] OUT_HI = VW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] OUT_LO = -OUT_HI - VW'(1);

	logic [8:0]  volume_q;
	logic        spat_en_q;
	logic [11:0] min_dist_q;
	logic [11:0] lst_off_q;

	logic               vv_q, last_q, spat_q;
	logic signed [15:0] smp_l_q, smp_r_q;
	logic signed [12:0] x_q, y_q, z_q;

	logic signed [42:0] prod_q;
	logic [27:0]        d2_q;
	logic [35:0]        rad_q;
	logic [19:0]        rem_q;
	logic [17:0]        root_q;
	logic [18:0]        drem_q;
	logic [15:0]        quo_q;
	logic               le_q;
	logic [16:0]        gain_q;
	logic signed [23:0] sum_l_q, sum_r_q;
	logic               clip_l_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q   <= VOLUME_RST;
			spat_en_q  <= 1'b0;
			min_dist_q <= MIN_DIST_RST;
			lst_off_q  <= LST_OFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VOLUME:          volume_q   <= cfg_data[8:0];
				REG_SPATIAL_ENABLE:  spat_en_q  <= cfg_data[0];
				REG_MIN_DISTANCE:    min_dist_q <= cfg_data[11:0];
				REG_LISTENER_OFFSET: lst_off_q  <= cfg_data[11:0];
				default:             volume_q   <= volume_q;
			endcase
		end
	end

	// multiplier operands
	logic signed [13:0] dx, dy, dz, dsel;
	logic signed [24:0] ma;
	logic signed [17:0] mb;
	logic signed [15:0] smp;
	logic signed [23:0] sum_sel;

	assign dy = {y_q[12], y_q};
	assign dz = {z_q[12], z_q};
	assign dx = cmd.side ? ({x_q[12], x_q} - $signed({2'b00, lst_off_q}))
	                     : ({x_q[12], x_q} + $signed({2'b00, lst_off_q}));
	assign smp     = cmd.side ? smp_r_q : smp_l_q;
	assign sum_sel = cmd.side ? sum_r_q : sum_l_q;

	always_comb begin
		dsel = dx;
		ma   = '0;
		mb   = '0;
		case (cmd.mul_sel)
			MS_DX, MS_DY, MS_DZ: begin
				dsel = (cmd.mul_sel == MS_DX) ? dx : ((cmd.mul_sel == MS_DY) ? dy : dz);
				ma   = {{11{dsel[13]}}, dsel};
				mb   = {{4{dsel[13]}}, dsel};
			end
			MS_GAIN: begin
				ma = {{9{smp[15]}}, smp};
				mb = $signed({1'b0, gain_q});
			end
			MS_SUM: begin
				ma = {sum_sel[23], sum_sel};
				mb = $signed({9'b0, volume_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// square root step: two radicand bits per cycle
	logic [21:0] sq_rem_n;
	logic [21:0] sq_trial;
	assign sq_rem_n = {rem_q, rad_q[35:34]};
	assign sq_trial = {2'b00, root_q, 2'b01};

	// divide step: dividend low half is zero
	logic [18:0] dv_t;
	logic [15:0] md16;
	assign dv_t = {drem_q[17:0], 1'b0};
	assign md16 = {min_dist_q, 4'b0};

	// accumulate with saturation
	logic signed [16:0] scaled;
	logic signed [24:0] acc_n;
	logic signed [23:0] acc_sat;
	assign scaled = prod_q[32:16];
	assign acc_n  = {sum_sel[23], sum_sel} + {{8{scaled[16]}}, scaled};
	always_comb begin
		if (acc_n[24] != acc_n[23]) acc_sat = acc_n[24] ? 24'sh800000 : 24'sh7FFFFF;
		else acc_sat = acc_n[23:0];
	end

	// output scaling and saturation
	logic signed [VW-1:0]          vol_v;
	logic signed [SAMPLE_BITS-1:0] vol_sat;
	logic                          vol_clip;
	assign vol_v = prod_q[33:8];
	always_comb begin
		vol_clip = 1'b1;
		if (vol_v > OUT_HI) vol_sat = OUT_HI[SAMPLE_BITS-1:0];
		else if (vol_v < OUT_LO) vol_sat = OUT_LO[SAMPLE_BITS-1:0];
		else begin
			vol_sat  = vol_v[SAMPLE_BITS-1:0];
			vol_clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (cmd.load) begin
			smp_l_q <= left_sample;
			smp_r_q <= stereo_voice ? right_sample : left_sample;
			x_q     <= pos_x;
			y_q     <= pos_y;
			z_q     <= pos_z;
		end
		if (cmd.d2_clr) d2_q <= '0;
		else if (cmd.d2_add) d2_q <= d2_q + prod_q[27:0];
		if (cmd.sqrt_init) begin
			rad_q  <= {d2_q, 8'b0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[33:0], 2'b00};
			if (sq_rem_n >= sq_trial) begin
				rem_q  <= 20'(sq_rem_n - sq_trial);
				root_q <= {root_q[16:0], 1'b1};
			end else begin
				rem_q  <= sq_rem_n[19:0];
				root_q <= {root_q[16:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			drem_q <= {3'b000, md16};
			quo_q  <= '0;
			le_q   <= (root_q <= {2'b00, md16});
		end else if (cmd.div_step) begin
			if (dv_t >= {1'b0, root_q}) begin
				drem_q <= dv_t - {1'b0, root_q};
				quo_q  <= {quo_q[14:0], 1'b1};
			end else begin
				drem_q <= dv_t;
				quo_q  <= {quo_q[14:0], 1'b0};
			end
		end
		if (cmd.gain_set) gain_q <= le_q ? GAIN_UNITY : {1'b0, quo_q};
		else if (cmd.gain_unity) gain_q <= GAIN_UNITY;
		if (cmd.lat_l) begin
			out_left <= vol_sat;
			clip_l_q <= vol_clip;
		end
		if (cmd.emit) begin
			out_right <= vol_sat;
			clipped   <= clip_l_q | vol_clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv_q        <= 1'b0;
			last_q      <= 1'b0;
			spat_q      <= 1'b0;
			sum_l_q     <= '0;
			sum_r_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				vv_q   <= voice_valid;
				last_q <= last_voice;
				spat_q <= spat_en_q & positional;
			end
			if (cmd.emit) begin
				sum_l_q <= '0;
				sum_r_q <= '0;
			end else if (cmd.acc) begin
				if (cmd.side) sum_r_q <= acc_sat;
				else sum_l_q <= acc_sat;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.vv       = vv_q;
	assign sts.last     = last_q;
	assign sts.spat     = spat_q;
	assign sts.out_busy = out_valid_q & out_stall;

endmodule

@@ design/stereo_mixer_distance_gain.sv @@
// stereo_mixer_distance_gain: top level of the stereo voice mixer.
// Instantiates smdg_ctrl and smdg_datapath; uses smdg_pkg.
//
// Usage: each input transaction carries one voice (or a frame-end marker).
// Voices add into 24-bit saturating stereo sums; a transaction with
// last_voice set scales both sums by volume, saturates them to SAMPLE_BITS
// and emits one output transaction. Config writes (cfg_we/cfg_index/cfg_data)
// take effect at the next edge and must be made while the block is idle;
// the block does not enforce this. Throughput: one voice at a time. A
// positional voice with spatial mode on runs the shared 18-step square
// root and 16-step divider once per side. Output appears in the cycle
// after OUT_SET. in_stall is high while a transaction is being worked on.
// A held output (out_stall high) blocks only the next frame emit; voices
// keep accumulating meanwhile. Reset clears sums, config to defaults and
// drops out_valid.
module stereo_mixer_distance_gain #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [smdg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smdg_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          voice_valid,
	input  logic signed [15:0]            left_sample,
	input  logic signed [15:0]            right_sample,
	input  logic                          stereo_voice,
	input  logic                          positional,
	input  logic signed [12:0]            pos_x,
	input  logic signed [12:0]            pos_y,
	input  logic signed [12:0]            pos_z,
	input  logic                          last_voice,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_left,
	output logic signed [SAMPLE_BITS-1:0] out_right,
	output logic                          clipped
);
	import smdg_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy;

	smdg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	smdg_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.voice_valid  (voice_valid),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.stereo_voice (stereo_voice),
		.positional   (positional),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.last_voice   (last_voice),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_left     (out_left),
		.out_right    (out_right),
		.clipped      (clipped)
	);

	assign in_stall = busy;

`ifndef ASSERT_OFF
	// one transaction in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in progress");

	// a result is only produced by the sequencer's emit step
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output raised outside of a frame emit");

	// a waiting result is not overwritten by the next frame
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_left) && $stable(out_right))
		else $error("pending output changed");
`endif

endmodule
